// File: hdl/pfcv_pkg.sv
// shared types, constants and the crc byte update for the package frame checker
// no dependencies
package pfcv_pkg;

  localparam int unsigned HdrBytes = 64;
  localparam logic [31:0] MagicValue = 32'h4B50_3944;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] MaxPayloadReset = 32'd524288;

  // header byte offsets
  localparam logic [5:0] OffVersion = 6'd4;
  localparam logic [5:0] OffSize = 6'd38;
  localparam logic [5:0] OffCrc = 6'd42;
  localparam logic [5:0] OffReserved = 6'd46;
  localparam logic [5:0] OffLast = 6'd63;

  typedef enum logic [0:0] {
    CfgMaxPayload = 1'b0,
    CfgHeaderOnly = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StShortHeader = 3'd1,
    StBadMagic = 3'd2,
    StBadSize = 3'd3,
    StShortPayload = 3'd4,
    StCrcMismatch = 3'd5
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] format_version;
    logic [31:0] payload_length;
    logic [31:0] expected_crc;
    logic [31:0] computed_crc;
  } verdict_t;

  // reflected crc-32, one byte, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/pfcv_parser.sv
// header parse, payload crc and verdict for one byte per cycle while accept_i is high
// depends on pfcv_pkg
module pfcv_parser import pfcv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  input  logic [31:0] max_payload_i,
  input  logic        header_only_i,
  output logic        emit_o,
  output verdict_t    verdict_o
);

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhWait    = 2'd2,
    PhWaitAlt = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] magic_q, magic_d;
  logic [15:0] version_q, version_d;
  logic [31:0] size_q, size_d;
  logic [31:0] crc_word_q, crc_word_d;
  logic [31:0] run_crc_q, run_crc_d;

  logic [31:0] pos_inc;
  logic [5:0]  hp;
  logic [31:0] crc_upd;
  logic        emit;
  verdict_t    vd;

  assign pos_inc = pos_q + 32'd1;
  assign hp      = pos_q[5:0];
  assign crc_upd = crc_byte(run_crc_q, data_byte_i);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    magic_d    = magic_q;
    version_d  = version_q;
    size_d     = size_q;
    crc_word_d = crc_word_q;
    run_crc_d  = run_crc_q;
    emit       = 1'b0;
    vd.status         = StOk;
    vd.format_version = version_q;
    vd.payload_length = size_q;
    vd.expected_crc   = crc_word_q;
    vd.computed_crc   = '0;

    unique case (phase_q)
      PhHeader: begin
        // little-endian field capture
        if (hp < OffVersion) begin
          magic_d[8*hp[1:0] +: 8] = data_byte_i;
        end else if (hp < 6'd6) begin
          version_d[8*hp[0] +: 8] = data_byte_i;
        end else if (hp >= OffSize && hp < OffCrc) begin
          size_d[8*(hp - OffSize) +: 8] = data_byte_i;
        end else if (hp >= OffCrc && hp < OffReserved) begin
          crc_word_d[8*(hp - OffCrc) +: 8] = data_byte_i;
        end
        pos_d = pos_inc;
        if (hp == OffLast) begin
          // all header fields are complete in the registers by now
          if (magic_q != MagicValue) begin
            emit = 1'b1;
            vd.status = StBadMagic;
          end else if (header_only_i) begin
            emit = 1'b1;
            vd.status = StOk;
          end else if (size_q == '0 || size_q > max_payload_i) begin
            emit = 1'b1;
            vd.status = StBadSize;
          end else begin
            phase_d = PhPayload;
            pos_d   = '0;
            if (end_of_file_i) begin
              emit = 1'b1;
              vd.status = StShortPayload;
            end
          end
        end else if (end_of_file_i) begin
          emit = 1'b1;
          vd.status         = StShortHeader;
          vd.format_version = '0;
          vd.payload_length = '0;
          vd.expected_crc   = '0;
        end
      end
      PhPayload: begin
        run_crc_d = crc_upd;
        pos_d     = pos_inc;
        if (pos_inc == size_q) begin
          emit = 1'b1;
          vd.computed_crc = ~crc_upd;
          vd.status = (~crc_upd == crc_word_q) ? StOk : StCrcMismatch;
        end else if (end_of_file_i) begin
          emit = 1'b1;
          vd.status = StShortPayload;
        end
      end
      PhWait, PhWaitAlt: begin
        // bytes ignored until the end mark
      end
      default: begin
      end
    endcase

    if (end_of_file_i) begin
      phase_d    = PhHeader;
      pos_d      = '0;
      magic_d    = '0;
      version_d  = '0;
      size_d     = '0;
      crc_word_d = '0;
      run_crc_d  = CrcInit;
    end else if (emit) begin
      phase_d = PhWait;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      pos_q      <= '0;
      magic_q    <= '0;
      version_q  <= '0;
      size_q     <= '0;
      crc_word_q <= '0;
      run_crc_q  <= CrcInit;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      magic_q    <= magic_d;
      version_q  <= version_d;
      size_q     <= size_d;
      crc_word_q <= crc_word_d;
      run_crc_q  <= run_crc_d;
    end
  end

  assign emit_o    = accept_i & emit;
  assign verdict_o = vd;

  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHeader |-> pos_q < 32'(HdrBytes))
    else $error("header position past header end");

  a_pay_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> pos_q < size_q)
    else $error("payload position reached size without verdict");

  a_wait_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhWait || phase_q == PhWaitAlt) |-> !emit)
    else $error("verdict raised while waiting for end mark");

endmodule

// File: hdl/pfcv_out_buf.sv
// result register with a skid stage so input can run while a verdict waits
// depends on pfcv_pkg
module pfcv_out_buf import pfcv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  verdict_t push_data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output verdict_t out_data_o
);

  logic     out_valid_q, skid_valid_q;
  verdict_t out_q, skid_q;
  logic     out_fire;

  assign out_fire = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i && push_i))
    else $error("skid filled without a stalled output");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("beat pushed while skid full");

endmodule

// File: hdl/package_frame_crc_verifier_core.sv
// package frame checker top level: config registers, parser and output buffer
// depends on pfcv_pkg, pfcv_parser, pfcv_out_buf
// a verdict is registered in the output register, or in the skid stage while the output stalls
// throughput: one byte per cycle unless stalled; crc byte update is eight combinational xor steps
// input stalls only while a verdict waits in both the output register and the skid stage
// reset is asynchronous, active low: frame state to header start, limit 524288, header-only off
module package_frame_crc_verifier_core import pfcv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  // verdict output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] format_version_o,
  output logic [31:0] payload_length_o,
  output logic [31:0] expected_crc_o,
  output logic [31:0] computed_crc_o
);

  // configuration registers, to be written only while idle; the block itself does not enforce this
  logic [31:0] max_payload_q;
  logic        header_only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
      header_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMaxPayload: max_payload_q <= cfg_wdata_i;
        CfgHeaderOnly: header_only_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // an input beat is taken whenever the skid stage has room
  logic     buf_full;
  logic     in_acc;
  logic     emit;
  verdict_t verdict;
  verdict_t out_data;

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i & ~buf_full;

  // per-byte frame parsing and crc, state updated on each accepted beat
  pfcv_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .max_payload_i (max_payload_q),
    .header_only_i (header_only_q),
    .emit_o        (emit),
    .verdict_o     (verdict)
  );

  // result register plus skid stage
  pfcv_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_data_i (verdict),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign status_o         = out_data.status;
  assign format_version_o = out_data.format_version;
  assign payload_length_o = out_data.payload_length;
  assign expected_crc_o   = out_data.expected_crc;
  assign computed_crc_o   = out_data.computed_crc;

  // a verdict only ever comes from an accepted beat
  a_emit_from_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> in_valid_i && !in_stall_o)
    else $error("verdict without accepted beat");

  // a new beat into an empty output shows up next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !out_valid_o |=> out_valid_o)
    else $error("verdict lost on the way out");

  // computed crc is only reported with an ok or mismatch verdict
  a_crc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && verdict.computed_crc != '0 |->
      verdict.status == StOk || verdict.status == StCrcMismatch)
    else $error("crc reported with a non-crc verdict");

endmodule
